### rtl/ufbd_pkg.sv
// shared types and constants for the uart fractional baud divisor search
// no dependencies; imported by every module of the block
`default_nettype none

package ufbd_pkg;

    localparam int CLK_W    = 29;
    localparam int BAUD_W   = 24;
    localparam int DIV_W    = 17;
    localparam int FRAC_W   = 15;
    localparam int NIB_W    = 4;
    localparam int NUM_W    = 32;
    localparam int DEN_W    = BAUD_W;
    localparam int DIV_CNT_W = 6;
    localparam int ERR_W    = DIV_W;

    localparam logic [CLK_W-1:0]     CLK_RESET   = 29'd100000000;
    localparam logic [NIB_W-1:0]     MUL_MAX     = 4'd15;
    localparam logic [DIV_CNT_W-1:0] RATIO_STEPS = 6'd32;
    localparam logic [DIV_CNT_W-1:0] SCALE_STEPS = 6'd15;
    localparam logic [DIV_CNT_W-1:0] CAND_STEPS  = 6'd17;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATIO,
        S_SCALE,
        S_CAND,
        S_DONE
    } search_state_t;

    // request to the serial divider: remainder preset, bits to shift in msb first
    typedef struct packed {
        logic                 start;
        logic [DEN_W-1:0]     rem_init;
        logic [NUM_W-1:0]     num;
        logic [DIV_CNT_W-1:0] count;
        logic [DEN_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic [DIV_W-1:0] integer_divisor;
        logic [NIB_W-1:0] multiplier;
        logic [NIB_W-1:0] divide_add;
        logic             bad_rate;
    } res_t;

endpackage

`default_nettype wire

### rtl/ufbd_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on ufbd_pkg
`default_nettype none

module ufbd_divider
    import ufbd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     q_reg, q_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            rem_next  = req.rem_init;
            q_next    = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

### rtl/ufbd_search.sv
// sequencer: ratio division, then scale and candidate divisions per pair
// depends on ufbd_pkg; drives ufbd_divider through div_req_t / div_rsp_t
`default_nettype none

module ufbd_search
    import ufbd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [BAUD_W-1:0] baud,
    input  wire logic [CLK_W-1:0]  clock_hz,
    output logic                   idle,
    output logic                   res_valid,
    input  wire logic              res_take,
    output res_t                   res,
    output div_req_t               req,
    input  wire div_rsp_t          rsp
);

    search_state_t    state_reg, state_next;
    div_req_t         req_reg, req_next;
    logic [NUM_W-1:0] ratio_reg, ratio_next;
    logic [NIB_W-1:0] m_reg, m_next;
    logic [NIB_W-1:0] a_reg, a_next;
    logic [ERR_W-1:0] best_err_reg, best_err_next;
    res_t             best_reg, best_next;
    logic [ERR_W-1:0] err;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        req_next.start = 1'b0;
        ratio_next    = ratio_reg;
        m_next        = m_reg;
        a_next        = a_reg;
        best_err_next = best_err_reg;
        best_next     = best_reg;
        err           = {1'b0, rsp.rem[ERR_W-2:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (baud == '0)
                    begin
                        best_next          = '0;
                        best_next.bad_rate = 1'b1;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        req_next.start    = 1'b1;
                        req_next.rem_init = '0;
                        req_next.num      = {clock_hz[CLK_W-1:4], 7'b0};
                        req_next.count    = RATIO_STEPS;
                        req_next.den      = baud;
                        state_next        = S_RATIO;
                    end
                end
            end
            S_RATIO:
            begin
                if (rsp.done)
                begin
                    // ratio = quotient << 8, wrapping at 32 bits
                    ratio_next                = {rsp.quo[23:0], 8'b0};
                    best_next.integer_divisor = rsp.quo[23:7];
                    best_next.multiplier      = 4'd1;
                    best_next.divide_add      = '0;
                    best_next.bad_rate        = 1'b0;
                    if (rsp.quo[6:0] == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        m_next            = 4'd2;
                        a_next            = 4'd1;
                        best_err_next     = '1;
                        req_next.start    = 1'b1;
                        req_next.rem_init = DEN_W'(4'd1);
                        req_next.num      = '0;
                        req_next.count    = SCALE_STEPS;
                        req_next.den      = DEN_W'(4'd2);
                        state_next        = S_SCALE;
                    end
                end
            end
            S_SCALE:
            begin
                if (rsp.done)
                begin
                    // scale = 32768 + (a << 15) / m, quotient fits 15 bits
                    req_next.start    = 1'b1;
                    req_next.rem_init = DEN_W'(ratio_reg[NUM_W-1:DIV_W]);
                    req_next.num      = {ratio_reg[DIV_W-1:0], {FRAC_W{1'b0}}};
                    req_next.count    = CAND_STEPS;
                    req_next.den      = DEN_W'({1'b1, rsp.quo[FRAC_W-1:0]});
                    state_next        = S_CAND;
                end
            end
            S_CAND:
            begin
                if (rsp.done)
                begin
                    if (err < best_err_reg)
                    begin
                        best_err_next             = err;
                        best_next.integer_divisor = rsp.quo[DIV_W-1:0];
                        best_next.multiplier      = m_reg;
                        best_next.divide_add      = a_reg;
                    end
                    if ((a_reg + 1'b1) < m_reg)
                    begin
                        a_next = a_reg + 1'b1;
                    end
                    else
                    begin
                        m_next = m_reg + 1'b1;
                        a_next = 4'd1;
                    end
                    if (((a_reg + 1'b1) >= m_reg) && (m_reg == MUL_MAX))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        req_next.start    = 1'b1;
                        req_next.rem_init = DEN_W'(a_next);
                        req_next.num      = '0;
                        req_next.count    = SCALE_STEPS;
                        req_next.den      = DEN_W'(m_next);
                        state_next        = S_SCALE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ratio_reg    <= ratio_next;
        m_reg        <= m_next;
        a_reg        <= a_next;
        best_err_reg <= best_err_next;
        best_reg     <= best_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = best_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

### rtl/uart_fractional_baud_divisor_search_top.sv
// top level of the uart fractional baud divisor search
// depends on ufbd_pkg, ufbd_divider and ufbd_search
`default_nettype none

// Give a baud rate beat on baud_rate and the block returns the divisor latch
// value and the fractional divider pair (multiplier, divide_add) for the
// peripheral clock held in the clock register (cfg_we / cfg_wdata, reset
// 100 MHz). A zero baud rate returns bad_rate with all other fields zero;
// the search goes straight to its done state, with no division. Otherwise
// one 32-step serial division forms the 17.15 clock-to-baud ratio; if its
// fraction is zero the result is given with multiplier 1 and add 0. Else all
// 105 pairs of multiplier 2..15 and add 1..multiplier-1 are tried, each
// taking a 15-step division for the scale and a 17-step division for the
// candidate. All divisions run on the single bit-serial divider. One baud
// rate is worked on at a time; the result sits in an output register so the
// next beat can be taken while it waits.

module uart_fractional_baud_divisor_search_top
    import ufbd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CLK_W-1:0]  cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BAUD_W-1:0] baud_rate,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DIV_W-1:0]       integer_divisor,
    output logic [NIB_W-1:0]       multiplier,
    output logic [NIB_W-1:0]       divide_add,
    output logic                   bad_rate
);

    // clock register
    logic [CLK_W-1:0] clock_reg, clock_next;

    // output register
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    // search side
    logic     search_idle;
    logic     res_valid;
    logic     res_take;
    res_t     res;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     in_beat;

    assign in_ready = search_idle;
    assign in_beat  = in_valid && in_ready;

    // result moves into the output register once it is empty or draining
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        clock_next     = cfg_we ? cfg_wdata : clock_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg     <= CLK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clock_reg     <= clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    ufbd_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_beat),
        .baud     (baud_rate),
        .clock_hz (clock_reg),
        .idle     (search_idle),
        .res_valid(res_valid),
        .res_take (res_take),
        .res      (res),
        .req      (div_req),
        .rsp      (div_rsp)
    );

    ufbd_divider u_divider (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign out_valid       = out_valid_reg;
    assign integer_divisor = out_reg.integer_divisor;
    assign multiplier      = out_reg.multiplier;
    assign divide_add      = out_reg.divide_add;
    assign bad_rate        = out_reg.bad_rate;

endmodule

`default_nettype wire

### rtl/ufbd_checker.sv
// port-level checks for the uart fractional baud divisor search
// depends on ufbd_pkg; bound to uart_fractional_baud_divisor_search_top
`default_nettype none

module ufbd_checker
    import ufbd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DIV_W-1:0]  integer_divisor,
    input wire logic [NIB_W-1:0]  multiplier,
    input wire logic [NIB_W-1:0]  divide_add,
    input wire logic              bad_rate
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(integer_divisor)
            && $stable(multiplier) && $stable(divide_add) && $stable(bad_rate))
        else $error("stalled result beat changed");

    // error result carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_rate |-> integer_divisor == '0 && multiplier == '0
            && divide_add == '0)
        else $error("bad rate result with nonzero fields");

    // fractional pair is always proper
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_rate |-> multiplier != '0 && divide_add < multiplier)
        else $error("improper multiplier / add pair");

    // a taken baud rate keeps the block busy the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an input beat");

endmodule

bind uart_fractional_baud_divisor_search_top ufbd_checker u_ufbd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .integer_divisor(integer_divisor),
    .multiplier     (multiplier),
    .divide_add     (divide_add),
    .bad_rate       (bad_rate)
);

`default_nettype wire
